FILE: rtl/core/chip8_instruction_core_assert.svh
// ----------------------------------------------------------------------------
// chip8 core assertion macros
// assertion helpers for the instruction core
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define C8_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define C8_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define C8_ASSERT(label, clk, rst_n, prop, msg)
`define C8_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/core/c8core_pkg.sv
// ----------------------------------------------------------------------------
// c8core_pkg
// shared types and constants of the chip8 instruction core
// ----------------------------------------------------------------------------
package c8core_pkg;
    localparam int MemBytes    = 4096;
    localparam int StackDepth  = 16;
    localparam logic [11:0] PcReset = 12'h200;

    localparam logic [1:0] FUNC_EXEC  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_MEMWR    = 4'd1,  // host byte write
        CMD_FETCH_HI = 4'd2,  // mem read at pc
        CMD_FETCH_LO = 4'd3,  // mem read at pc+1, latch hi
        CMD_DECODE   = 4'd4,  // latch opcode, pc+=2
        CMD_SIMPLE   = 4'd5,  // simple ops of the execute state
        CMD_CLEAR    = 4'd6,  // clear one row
        CMD_DRAW_RD  = 4'd7,  // mem read at I+cnt
        CMD_DRAW_WR  = 4'd8,  // xor one row
        CMD_BCD_WR   = 4'd9,  // write one bcd digit
        CMD_ST_WR    = 4'd10, // store one reg
        CMD_LD_RD    = 4'd11, // mem read at I+cnt
        CMD_LD_WR    = 4'd12, // write one reg
        CMD_ROWRD    = 4'd13, // display row read
        CMD_CNT_CLR  = 4'd14  // clear loop counter and flags
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic       cnt_inc;
    } t_ctrl;

    typedef struct packed {
        logic [15:0] opcode;
        logic [5:0]  cnt;
        logic        draw_last;  // draw loop at final row
        logic        ld_last;    // store/load at final reg
    } t_stat;

    function automatic logic [3:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
        logic [7:0] h, t, u;
        logic [3:0] d;
        h = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
        t = v - 8'(h * 8'd100);
        // tens by compare against each multiple of ten
        d = 4'd0;
        for (int j = 1; j < 10; j++) if (t >= 8'(j * 10)) d = 4'(j);
        u = t - 8'({4'd0, d} * 8'd10);
        case (k)
            2'd0:    bcd_digit = h[3:0];
            2'd1:    bcd_digit = d;
            default: bcd_digit = u[3:0];
        endcase
    endfunction
endpackage

FILE: rtl/core/c8core_datapath.sv
// ----------------------------------------------------------------------------
// c8core_datapath
// registers, memory, stack and frame buffer of the chip8 core
// ----------------------------------------------------------------------------
module c8core_datapath
    import c8core_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic [7:0]  i_rand_byte,
    input  logic [11:0] i_load_addr,
    input  logic [7:0]  i_load_data,
    input  logic [4:0]  i_row_select,
    output t_stat       o_stat,
    output logic [11:0] o_pc_out,
    output logic [15:0] o_index_out,
    output logic [7:0]  o_flag_out,
    output logic        o_screen_changed,
    output logic        o_stack_fault,
    output logic [63:0] o_display_row
);
    localparam int SpW = $clog2(STACK_DEPTH + 1);
    localparam int SiW = $clog2(STACK_DEPTH);

    logic [7:0]  r_mem [MemBytes];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [63:0] r_frame [32];
    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [11:0] r_pc;
    logic [SpW-1:0] r_sp;
    logic [15:0] r_op;
    logic [7:0]  r_hi;
    logic [7:0]  r_rd;
    logic [5:0]  r_cnt;
    logic        r_chg, r_flt;
    logic [63:0] r_row;
    logic [7:0]  r_rand;
    logic [5:0]  r_col;
    logic [4:0]  r_top;

    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn, mem_addr, i_off;
    logic        mem_we;
    logic [7:0]  mem_wd;
    logic [5:0]  col;
    logic [4:0]  top, line;
    logic [5:0]  line_full;
    logic [63:0] spr;
    t_cmd        cmd;

    assign cmd  = i_ctrl.cmd;
    assign x    = r_op[11:8];
    assign y    = r_op[7:4];
    assign n    = r_op[3:0];
    assign kk   = r_op[7:0];
    assign nnn  = r_op[11:0];
    assign vx   = r_v[x];
    assign vy   = r_v[y];
    assign i_off = r_i[11:0] + {6'd0, r_cnt};
    // sprite position taken before VF is touched
    assign col  = r_col;
    assign top  = r_top;
    assign line_full = {1'b0, top} + r_cnt;
    assign line = line_full[4:0];
    assign spr  = ({r_rd, 56'd0}) >> col;

    // memory port control
    always_comb begin
        mem_addr = r_pc;
        mem_we   = 1'b0;
        mem_wd   = i_load_data;
        case (cmd)
            CMD_MEMWR:    begin mem_addr = i_load_addr; mem_we = 1'b1; end
            CMD_FETCH_LO: mem_addr = r_pc + 12'd1;
            CMD_DRAW_RD, CMD_LD_RD: mem_addr = i_off;
            CMD_BCD_WR: begin
                mem_addr = i_off; mem_we = 1'b1;
                mem_wd = {4'd0, bcd_digit(vx, r_cnt[1:0])};
            end
            CMD_ST_WR: begin mem_addr = i_off; mem_we = 1'b1; mem_wd = r_v[r_cnt[3:0]]; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_rd <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            for (int k = 0; k < 32; k++) r_frame[k] <= 64'd0;
            r_i <= 16'd0; r_pc <= PcReset; r_sp <= '0;
            r_cnt <= '0; r_chg <= 1'b0; r_flt <= 1'b0; r_row <= 64'd0;
        end else begin
            if (i_ctrl.cnt_inc) r_cnt <= r_cnt + 6'd1;
            case (cmd)
                CMD_CNT_CLR: begin
                    r_cnt <= '0; r_chg <= 1'b0; r_flt <= 1'b0; r_row <= 64'd0;
                    r_rand <= i_rand_byte;
                end
                CMD_MEMWR: begin r_chg <= 1'b0; r_flt <= 1'b0; r_row <= 64'd0; end
                CMD_ROWRD: begin
                    r_row <= r_frame[i_row_select]; r_chg <= 1'b0; r_flt <= 1'b0;
                end
                CMD_FETCH_LO: r_hi <= r_rd;
                CMD_DECODE: begin
                    r_op <= {r_hi, r_rd};
                    r_pc <= r_pc + 12'd2;
                end
                CMD_CLEAR: begin
                    if (r_frame[r_cnt[4:0]] != 64'd0) r_chg <= 1'b1;
                    r_frame[r_cnt[4:0]] <= 64'd0;
                end
                CMD_DRAW_WR: begin
                    if ((r_frame[line] & spr) != 64'd0) r_v[15] <= 8'd1;
                    if (spr != 64'd0) r_chg <= 1'b1;
                    r_frame[line] <= r_frame[line] ^ spr;
                end
                CMD_LD_WR: r_v[r_cnt[3:0]] <= r_rd;
                CMD_SIMPLE: begin
                    case (r_op[15:12])
                        4'h0: begin
                            if (r_sp == '0) r_flt <= 1'b1;
                            else begin
                                r_sp <= r_sp - 1'b1;
                                r_pc <= r_stack[SiW'(r_sp - 1'b1)];
                            end
                        end
                        4'h1: r_pc <= nnn;
                        4'h2: begin
                            if (r_sp >= SpW'(STACK_DEPTH)) r_flt <= 1'b1;
                            else begin
                                r_stack[SiW'(r_sp)] <= r_pc;
                                r_sp <= r_sp + 1'b1;
                                r_pc <= nnn;
                            end
                        end
                        4'h3: if (vx == kk) r_pc <= r_pc + 12'd2;
                        4'h4: if (vx != kk) r_pc <= r_pc + 12'd2;
                        4'h5: if (vx == vy) r_pc <= r_pc + 12'd2;
                        4'h6: r_v[x] <= kk;
                        4'h7: r_v[x] <= vx + kk;
                        4'h8: begin
                            case (n)
                                4'h0: r_v[x] <= vy;
                                4'h1: r_v[x] <= vx | vy;
                                4'h2: r_v[x] <= vx & vy;
                                4'h3: r_v[x] <= vx ^ vy;
                                4'h4: begin
                                    r_v[x] <= vx + vy;
                                    r_v[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'h0FF};
                                end
                                4'h5: begin r_v[x] <= vx - vy; r_v[15] <= {7'd0, vx >= vy}; end
                                4'h6: begin r_v[x] <= vx >> 1; r_v[15] <= {7'd0, vx[0]}; end
                                4'h7: begin r_v[x] <= vy - vx; r_v[15] <= {7'd0, vy >= vx}; end
                                4'hE: begin r_v[x] <= vx << 1; r_v[15] <= {7'd0, vx[7]}; end
                                default: ;
                            endcase
                        end
                        4'h9: if (vx != vy) r_pc <= r_pc + 12'd2;
                        4'hA: r_i <= {4'd0, nnn};
                        4'hB: r_pc <= nnn + {4'd0, vx};
                        4'hC: r_v[x] <= r_rand & kk;
                        4'hD: begin
                            r_v[15] <= 8'd0;
                            r_col <= vx[5:0];
                            r_top <= vy[4:0];
                        end
                        4'hF: if (kk == 8'h1E) r_i <= r_i + {8'd0, vx};
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_stat.opcode    = r_op;
    assign o_stat.cnt       = r_cnt;
    assign o_stat.draw_last = (r_cnt == {2'd0, n} - 6'd1) || line_full == 6'd31 || n == 4'd0;
    assign o_stat.ld_last   = (r_cnt[3:0] == x);
    assign o_pc_out         = r_pc;
    assign o_index_out      = r_i;
    assign o_flag_out       = r_v[15];
    assign o_screen_changed = r_chg;
    assign o_stack_fault    = r_flt;
    assign o_display_row    = r_row;
endmodule

FILE: rtl/core/c8core_ctrl.sv
// ----------------------------------------------------------------------------
// c8core_ctrl
// sequencer of the chip8 core
// ----------------------------------------------------------------------------
module c8core_ctrl
    import c8core_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl,
    output logic       o_valid,
    input  logic       i_ready
);
    `include "chip8_instruction_core_assert.svh"

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FHI    = 11'b00000000010,
        S_FLO    = 11'b00000000100,
        S_DEC    = 11'b00000001000,
        S_EXEC   = 11'b00000010000,
        S_CLEAR  = 11'b00000100000,
        S_DRD    = 11'b00001000000,
        S_DWAIT  = 11'b00010000000,
        S_DWR    = 11'b00100000000,
        S_LDWR   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] op;
    logic        accept;

    assign op      = i_stat.opcode;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state        = r_state;
        o_ctrl.cmd     = CMD_NONE;
        o_ctrl.cnt_inc = 1'b0;
        case (r_state)
            S_IDLE: if (accept) begin
                // host items bypass the execute path
                case (i_func)
                    FUNC_EXEC:  begin o_ctrl.cmd = CMD_CNT_CLR; n_state = S_FHI; end
                    FUNC_WRITE: begin o_ctrl.cmd = CMD_MEMWR; n_state = S_OUT; end
                    FUNC_READ:  begin o_ctrl.cmd = CMD_ROWRD; n_state = S_OUT; end
                    default:    begin o_ctrl.cmd = CMD_CNT_CLR; n_state = S_OUT; end
                endcase
            end
            S_FHI: begin o_ctrl.cmd = CMD_FETCH_HI; n_state = S_FLO; end
            S_FLO: begin o_ctrl.cmd = CMD_FETCH_LO; n_state = S_DEC; end
            S_DEC: begin o_ctrl.cmd = CMD_DECODE; n_state = S_EXEC; end
            S_EXEC: begin
                if (op == 16'h00E0) n_state = S_CLEAR;
                else if (op[15:12] == 4'hD) begin
                    o_ctrl.cmd = CMD_SIMPLE;
                    n_state = (op[3:0] == 4'd0) ? S_OUT : S_DRD;
                end else if (op[15:12] == 4'hF &&
                             (op[7:0] == 8'h33 || op[7:0] == 8'h55 || op[7:0] == 8'h65))
                    n_state = S_DWAIT;
                else begin
                    if (op[15:12] != 4'h0 || op == 16'h00EE) o_ctrl.cmd = CMD_SIMPLE;
                    n_state = S_OUT;
                end
            end
            S_CLEAR: begin
                o_ctrl.cmd = CMD_CLEAR; o_ctrl.cnt_inc = 1'b1;
                if (i_stat.cnt == 6'd31) n_state = S_OUT;
            end
            S_DRD: begin o_ctrl.cmd = CMD_DRAW_RD; n_state = S_DWR; end
            S_DWR: begin
                o_ctrl.cmd = CMD_DRAW_WR; o_ctrl.cnt_inc = 1'b1;
                n_state = i_stat.draw_last ? S_OUT : S_DRD;
            end
            S_DWAIT: begin
                // bcd, store and load loops
                if (op[7:0] == 8'h33) begin
                    o_ctrl.cmd = CMD_BCD_WR; o_ctrl.cnt_inc = 1'b1;
                    if (i_stat.cnt == 6'd2) n_state = S_OUT;
                end else if (op[7:0] == 8'h55) begin
                    o_ctrl.cmd = CMD_ST_WR; o_ctrl.cnt_inc = 1'b1;
                    if (i_stat.ld_last) n_state = S_OUT;
                end else begin
                    o_ctrl.cmd = CMD_LD_RD; n_state = S_LDWR;
                end
            end
            S_LDWR: begin
                o_ctrl.cmd = CMD_LD_WR; o_ctrl.cnt_inc = 1'b1;
                n_state = i_stat.ld_last ? S_OUT : S_DWAIT;
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    `C8_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    `C8_ASSERT(a_excl, i_clk, i_rst_n, !(o_valid && o_ready), "ready while result pending")
    `C8_ASSERT_NEXT(a_fetch_seq, i_clk, i_rst_n, r_state == S_FHI, r_state == S_FLO, "fetch order")
endmodule

FILE: rtl/core/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// chip8 interpreter core: one item is an instruction step, a memory byte
// write, a display row read or a state report; one result word per item
// ----------------------------------------------------------------------------
// Each accepted word yields one result word holding pc, I, VF, change and
// fault flags and (for a row read) the display row. Only one word is in
// flight. Byte writes and row reads go from the accept straight to the
// result; a plain instruction steps through accept, fetch hi, fetch lo,
// decode, execute and result. Clear screen walks the 32 frame rows, one a
// cycle. Draw reads each sprite row over the single memory port, then xors
// it in; BCD 3 writes, register store x+1 writes and load x+1 read/write
// pairs. The one read/write port of program memory sets these loop lengths.
// Memory and stack contents are undefined until written; registers, pc
// (0x200), I, stack pointer and frame buffer reset synchronously.
// ----------------------------------------------------------------------------
module chip8_instruction_core
    import c8core_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rand_byte,
    input  logic [11:0] i_load_addr,
    input  logic [7:0]  i_load_data,
    input  logic [4:0]  i_row_select,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_pc_out,
    output logic [15:0] o_index_out,
    output logic [7:0]  o_flag_out,
    output logic        o_screen_changed,
    output logic        o_stack_fault,
    output logic [63:0] o_display_row
);
    t_ctrl ctrl;
    t_stat stat;

    // sequencer
    c8core_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func,
        .i_stat(stat), .o_ctrl(ctrl), .o_valid, .i_ready
    );

    // state and execution units
    c8core_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_ctrl(ctrl), .i_rand_byte, .i_load_addr,
        .i_load_data, .i_row_select, .o_stat(stat), .o_pc_out, .o_index_out,
        .o_flag_out, .o_screen_changed, .o_stack_fault, .o_display_row
    );
endmodule

FILE: tb/chip8_instruction_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_test
// self-checking bench for the chip8 instruction core: a scoreboard class
// mirrors the core (registers, stack, frame buffer, memory) and predicts the
// result word of every accepted input word; plain tasks build small programs
// in memory, execute them, poke bytes and read display rows under random
// idling on both sides
// ----------------------------------------------------------------------------
module chip8_instruction_core_test;
    import c8core_pkg::*;

    localparam logic [1:0] FUNC_IDLE = 2'd3;   // unused func, reports state only
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TARGET_WORDS = 1150;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  flag;
        logic        chg;
        logic        flt;
        logic [63:0] row;
    } t_c8_result;

    // mirror of the core plus the queue of result words still owed
    class c8_scoreboard;
        bit [7:0]    regs[16];
        bit [15:0]   idx;
        bit [11:0]   pc;
        bit [11:0]   stk[StackDepth];
        int unsigned sp;
        bit [63:0]   rows[32];
        bit [7:0]    mem[MemBytes];
        bit          known[MemBytes];   // byte written at least once
        t_c8_result  owed[$];
        int errors, checked, n_words, n_exec, n_chg, n_flt, n_rows;

        function new();
            pc = PcReset;
        endfunction

        function void alu_op(bit [3:0] x, bit [3:0] y, bit [3:0] op);
            bit [7:0] vx, vy;
            bit [8:0] sum;
            vx = regs[x];
            vy = regs[y];
            sum = {1'b0, vx} + {1'b0, vy};
            case (op)
                4'h0: regs[x] = vy;
                4'h1: regs[x] = vx | vy;
                4'h2: regs[x] = vx & vy;
                4'h3: regs[x] = vx ^ vy;
                // flag is written last so it wins when x is VF
                4'h4: begin regs[x] = sum[7:0]; regs[15] = {7'd0, sum[8]}; end
                4'h5: begin regs[x] = vx - vy; regs[15] = {7'd0, vx >= vy}; end
                4'h6: begin regs[x] = vx >> 1; regs[15] = {7'd0, vx[0]}; end
                4'h7: begin regs[x] = vy - vx; regs[15] = {7'd0, vy >= vx}; end
                4'hE: begin regs[x] = vx << 1; regs[15] = {7'd0, vx[7]}; end
                default: ;
            endcase
        endfunction

        function bit draw_sprite(bit [3:0] x, bit [3:0] y, bit [3:0] n);
            bit [5:0]  col;
            bit [4:0]  top;
            bit [63:0] spr;
            bit        chg;
            int        r;
            col = regs[x][5:0];
            top = regs[y][4:0];
            chg = 0;
            regs[15] = 0;
            for (r = 0; r < n; r++) begin
                // rows below the bottom edge are clipped, not wrapped
                if (int'(top) + r >= 32) break;
                spr = {mem[idx[11:0] + 12'(r)], 56'd0} >> col;
                if ((rows[int'(top) + r] & spr) != 0) regs[15] = 8'd1;
                if (spr != 0) chg = 1;
                rows[int'(top) + r] ^= spr;
            end
            return chg;
        endfunction

        function void put_byte(bit [11:0] a, bit [7:0] v);
            mem[a] = v;
            known[a] = 1;
        endfunction

        function void run_opcode(bit [7:0] rnd, output bit chg, output bit flt);
            bit [15:0] op;
            bit [3:0]  x, y, n;
            bit [7:0]  kk;
            bit [11:0] nnn;
            int        i;
            op = {mem[pc], mem[pc + 12'd1]};
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            kk = op[7:0];
            nnn = op[11:0];
            chg = 0;
            flt = 0;
            pc = pc + 12'd2;
            case (op[15:12])
                4'h0: begin
                    if (op == 16'h00E0) begin
                        foreach (rows[j]) if (rows[j] != 0) chg = 1;
                        foreach (rows[j]) rows[j] = 0;
                    end else if (op == 16'h00EE) begin
                        if (sp == 0) flt = 1;     // return on empty stack
                        else begin
                            sp--;
                            pc = stk[sp];
                        end
                    end
                end
                4'h1: pc = nnn;
                4'h2: begin
                    if (sp >= StackDepth) flt = 1;   // call on full stack
                    else begin
                        stk[sp] = pc;
                        sp++;
                        pc = nnn;
                    end
                end
                4'h3: if (regs[x] == kk) pc = pc + 12'd2;
                4'h4: if (regs[x] != kk) pc = pc + 12'd2;
                4'h5: if (regs[x] == regs[y]) pc = pc + 12'd2;
                4'h6: regs[x] = kk;
                4'h7: regs[x] = regs[x] + kk;
                4'h8: alu_op(x, y, n);
                4'h9: if (regs[x] != regs[y]) pc = pc + 12'd2;
                4'hA: idx = {4'd0, nnn};
                4'hB: pc = nnn + {4'd0, regs[x]};
                4'hC: regs[x] = rnd & kk;
                4'hD: chg = draw_sprite(x, y, n);
                4'hF: begin
                    if (kk == 8'h1E) idx = idx + {8'd0, regs[x]};
                    else if (kk == 8'h33) begin
                        put_byte(idx[11:0], regs[x] / 8'd100);
                        put_byte(idx[11:0] + 12'd1, (regs[x] / 8'd10) % 8'd10);
                        put_byte(idx[11:0] + 12'd2, regs[x] % 8'd10);
                    end else if (kk == 8'h55) begin
                        for (i = 0; i <= x; i++) put_byte(idx[11:0] + 12'(i), regs[i]);
                    end else if (kk == 8'h65) begin
                        for (i = 0; i <= x; i++) regs[i] = mem[idx[11:0] + 12'(i)];
                    end
                end
                default: ;
            endcase
        endfunction

        // accepted input word: advance the mirror and owe one result word
        function void note_word(logic [1:0] func, logic [7:0] rnd, logic [11:0] addr,
                                logic [7:0] data, logic [4:0] rsel);
            t_c8_result e;
            bit chg, flt;
            e = '0;
            chg = 0;
            flt = 0;
            n_words++;
            if (func == FUNC_EXEC) begin
                run_opcode(rnd, chg, flt);
                n_exec++;
                n_chg += chg;
                n_flt += flt;
            end else if (func == FUNC_WRITE) put_byte(addr, data);
            else if (func == FUNC_READ) begin
                e.row = rows[rsel];
                n_rows++;
            end
            e.pc = pc;
            e.idx = idx;
            e.flag = regs[15];
            e.chg = chg;
            e.flt = flt;
            owed = {owed, e};
        endfunction

        function void check_word(t_c8_result act);
            t_c8_result e;
            if (owed.size() == 0) begin
                $error("result word with nothing owed: pc %h", act.pc);
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            if (act.pc !== e.pc) begin
                $error("pc_out: expected %h actual %h", e.pc, act.pc);
                errors++;
            end
            if (act.idx !== e.idx) begin
                $error("index_out: expected %h actual %h", e.idx, act.idx);
                errors++;
            end
            if (act.flag !== e.flag) begin
                $error("flag_out: expected %h actual %h", e.flag, act.flag);
                errors++;
            end
            if (act.chg !== e.chg) begin
                $error("screen_changed: expected %b actual %b", e.chg, act.chg);
                errors++;
            end
            if (act.flt !== e.flt) begin
                $error("stack_fault: expected %b actual %b", e.flt, act.flt);
                errors++;
            end
            if (act.row !== e.row) begin
                $error("display_row: expected %h actual %h", e.row, act.row);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [7:0]  i_rand_byte;
    logic [11:0] i_load_addr;
    logic [7:0]  i_load_data;
    logic [4:0]  i_row_select;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_pc_out;
    logic [15:0] o_index_out;
    logic [7:0]  o_flag_out;
    logic        o_screen_changed;
    logic        o_stack_fault;
    logic [63:0] o_display_row;

    c8_scoreboard sb = new();
    bit calm;              // stretch with no idling on either side
    int cycles;

    chip8_instruction_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_rand_byte      (i_rand_byte),
        .i_load_addr      (i_load_addr),
        .i_load_data      (i_load_data),
        .i_row_select     (i_row_select),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pc_out         (o_pc_out),
        .o_index_out      (o_index_out),
        .o_flag_out       (o_flag_out),
        .o_screen_changed (o_screen_changed),
        .o_stack_fault    (o_stack_fault),
        .o_display_row    (o_display_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the core hangs
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // offer one word, wait for the handshake, then maybe idle
    task automatic send_word(input logic [1:0] func, input logic [7:0] rnd,
                             input logic [11:0] addr, input logic [7:0] data,
                             input logic [4:0] rsel);
        int gap;
        i_valid <= 1'b1;
        i_func <= func;
        i_rand_byte <= rnd;
        i_load_addr <= addr;
        i_load_data <= data;
        i_row_select <= rsel;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(func, rnd, addr, data, rsel);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // memory is undefined until written, so every byte the core will read
    // gets a random value first
    task automatic fill_byte(input logic [11:0] a);
        if (!sb.known[a]) send_word(FUNC_WRITE, 8'($urandom), a, 8'($urandom), 5'($urandom));
    endtask

    // optionally place an opcode at pc, make sure everything it reads
    // is written, then execute it
    task automatic run_exec(input bit put, input logic [15:0] op);
        logic [11:0] pc0;
        logic [15:0] cur;
        int cnt, k;
        pc0 = sb.pc;
        if (put) begin
            send_word(FUNC_WRITE, 8'($urandom), pc0, op[15:8], 5'($urandom));
            send_word(FUNC_WRITE, 8'($urandom), pc0 + 12'd1, op[7:0], 5'($urandom));
        end
        fill_byte(pc0);
        fill_byte(pc0 + 12'd1);
        cur = {sb.mem[pc0], sb.mem[pc0 + 12'd1]};
        cnt = 0;
        if (cur[15:12] == 4'hD) cnt = cur[3:0];                           // sprite rows
        else if (cur[15:12] == 4'hF && cur[7:0] == 8'h65) cnt = cur[11:8] + 1; // reg load
        for (k = 0; k < cnt; k++) fill_byte(sb.idx[11:0] + 12'(k));
        send_word(FUNC_EXEC, 8'($urandom), 12'($urandom), 8'($urandom), 5'($urandom));
    endtask

    // random opcode, weighted toward draw, alu, load immediate and Fx forms
    function automatic logic [15:0] gen_opcode();
        logic [31:0] r;
        logic [3:0]  hi;
        int          k;
        logic [7:0]  fx[5];
        fx = '{8'h1E, 8'h33, 8'h55, 8'h65, 8'h00};
        r = $urandom;
        k = $urandom_range(0, 19);
        hi = (k < 16) ? 4'(k) : (k == 16) ? 4'hD : (k == 17) ? 4'h8 : (k == 18) ? 4'h6 : 4'hF;
        gen_opcode = {hi, r[11:0]};
        case (hi)
            4'h0: begin
                if (r[13:12] == 2'd0) gen_opcode = 16'h00E0;
                else if (r[13:12] == 2'd1) gen_opcode = 16'h00EE;
            end
            4'h8: if (r[16:14] != 3'd0) begin
                // mostly defined alu ops, sometimes an unused low nibble
                gen_opcode[3:0] = (r[19:17] == 3'd0) ? 4'hE : 4'(r[19:17]);
            end
            4'hF: begin
                fx[4] = r[27:20];
                gen_opcode[7:0] = fx[$urandom_range(0, 4)];
            end
            default: ;
        endcase
    endfunction

    // nest calls one past the stack depth, then return one past empty
    task automatic call_burst();
        repeat (StackDepth + 1) run_exec(1'b1, {4'h2, sb.pc + 12'd2});
        repeat (StackDepth + 1) run_exec(1'b1, 16'h00EE);
    endtask

    // receiver: random back-pressure plus one long hold-off with a result pending
    initial begin : result_side
        int  hold;
        bit  pressed;
        t_c8_result act;
        hold = 0;
        pressed = 0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                act.pc = o_pc_out;
                act.idx = o_index_out;
                act.flag = o_flag_out;
                act.chg = o_screen_changed;
                act.flt = o_stack_fault;
                act.row = o_display_row;
                sb.check_word(act);
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (!pressed && sb.checked >= 300) begin
                // long stall while the sender keeps offering
                pressed = 1;
                hold = 600;
                i_ready <= 1'b0;
            end else begin
                hold = pick_gap();
                i_ready <= (hold == 0);
            end
        end
    end

    initial begin : word_side
        int k, bursts;
        bursts = 0;
        calm = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_func <= FUNC_EXEC;
        i_rand_byte <= '0;
        i_load_addr <= '0;
        i_load_data <= '0;
        i_row_select <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: cleared screen, unused func, top and bottom of memory
        send_word(FUNC_READ, 8'h00, 12'h000, 8'h00, 5'd31);
        send_word(FUNC_IDLE, 8'hFF, 12'hFFF, 8'hFF, 5'd0);
        send_word(FUNC_WRITE, 8'h00, 12'hFFF, 8'hFF, 5'd0);
        send_word(FUNC_WRITE, 8'h00, 12'h000, 8'h81, 5'd0);
        run_exec(1'b1, 16'h00EE);   // return with empty stack
        run_exec(1'b1, 16'h603F);   // V0 = 63, sprite at the right edge
        run_exec(1'b1, 16'hAFFF);   // I at the top, sprite read wraps to 0
        run_exec(1'b1, 16'hD012);   // draw, mostly clipped on the right
        send_word(FUNC_READ, 8'h00, 12'h000, 8'h00, 5'd1);
        run_exec(1'b1, 16'h8F04);   // add into VF, flag wins
        run_exec(1'b1, 16'hF033);   // bcd across the address wrap
        run_exec(1'b1, 16'h00E0);   // clear a dirty screen

        // random programs, pokes and row reads
        while (sb.n_words < TARGET_WORDS) begin
            calm = ((sb.n_words / 150) % 3 == 2);
            k = $urandom_range(0, 99);
            if (k < 45) run_exec(1'b0, 16'h0000);
            else if (k < 67) run_exec(1'b1, gen_opcode());
            else if (k < 79) send_word(FUNC_READ, 8'($urandom), 12'($urandom),
                                       8'($urandom), 5'($urandom));
            else if (k < 91) send_word(FUNC_WRITE, 8'($urandom), 12'($urandom),
                                       8'($urandom), 5'($urandom));
            else if (k < 93) send_word(FUNC_IDLE, 8'($urandom), 12'($urandom),
                                       8'($urandom), 5'($urandom));
            else if (k < 95 && bursts < 3) begin
                bursts++;
                call_burst();
            end else run_exec(1'b1, gen_opcode());
        end
        i_valid <= 1'b0;

        // drain, then keep watching for a stray word
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d words: %0d instructions, %0d screen changes, %0d stack faults,",
                 sb.n_words, sb.n_exec, sb.n_chg, sb.n_flt);
        $display("%0d row reads, %0d results checked in %0d cycles",
                 sb.n_rows, sb.checked, cycles);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/c8core_pkg.sv
rtl/core/c8core_datapath.sv
rtl/core/c8core_ctrl.sv
rtl/core/chip8_instruction_core.sv
tb/chip8_instruction_core_test.sv
